// ===== hw/rtl/stfl_pkg.sv =====
// ----------------------------------------------------------------------------
// stfl_pkg
// Shared types and constants of the slot table with free list.
// ----------------------------------------------------------------------------
package stfl_pkg;

   localparam int CAPACITY   = 256;
   localparam int VALUE_BITS = 32;
   localparam int SLOT_BITS  = $clog2(CAPACITY);
   localparam int ENTRY_BITS = VALUE_BITS + 1;

   localparam logic [1:0] OP_ADD    = 2'd0;
   localparam logic [1:0] OP_GET    = 2'd1;
   localparam logic [1:0] OP_REMOVE = 2'd2;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_FULL = 2'd1;
   localparam logic [1:0] ST_BAD  = 2'd2;

   typedef enum logic {
      STATE_IDLE,
      STATE_EXEC
   } state_type;

   typedef struct packed {
      logic [1:0]  op;
      logic [7:0]  slot_index;
      logic [31:0] item_value;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [7:0]  assigned_index;
      logic [31:0] read_value;
      logic [7:0]  live_count;
   } rsp_type;

endpackage

// ===== hw/rtl/stfl_ram.sv =====
// ----------------------------------------------------------------------------
// stfl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module stfl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/slot_table_with_free_list.sv =====
// ----------------------------------------------------------------------------
// slot_table_with_free_list
// Slot table with a LIFO free list threaded through the free slots.
// ----------------------------------------------------------------------------
// An item is accepted in IDLE, where its slot is read from the slot RAM into
// registered read data, and executed in EXEC, where it is checked, its slot
// written back if the op changes it, and the free list head and live count
// updated as the op requires. A new item is taken the cycle after EXEC. The
// result sits in an output register, so the next item is accepted while it
// waits; that item holds in EXEC until the output register frees up. Entries
// never written since reset read as free, linked to the next slot, through
// one valid flop per entry, so no clearing pass is needed after reset.
module slot_table_with_free_list (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  stfl_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output stfl_pkg::rsp_type rsp_data
);

   localparam int SB = stfl_pkg::SLOT_BITS;
   localparam int VB = stfl_pkg::VALUE_BITS;
   localparam int EB = stfl_pkg::ENTRY_BITS;

   stfl_pkg::state_type state_ff, state_in;

   logic [SB-1:0]            free_head_ff, free_head_in;
   logic [SB-1:0]            count_ff, count_in;
   logic [stfl_pkg::CAPACITY-1:0] slot_valid_ff;

   stfl_pkg::req_type        req_hold_ff;
   logic [SB-1:0]            addr_ff;
   logic                     hit_ff;

   logic                     rsp_valid_ff, rsp_valid_in;
   stfl_pkg::rsp_type        rsp_data_ff, rsp_data_in;

   logic                     accept;
   logic                     exec_go;
   logic [SB-1:0]            rd_addr;
   logic [EB-1:0]            rd_data;
   logic [EB-1:0]            entry;
   logic [VB-1:0]            reset_link;
   logic                     wr_en;
   logic [EB-1:0]            wr_data;
   logic                     idx_bad;

   // control
   always_comb begin
      state_in  = state_ff;
      req_stall = 1'b1;
      exec_go   = 1'b0;
      unique case (state_ff)
         stfl_pkg::STATE_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               state_in = stfl_pkg::STATE_EXEC;
            end
         end
         stfl_pkg::STATE_EXEC: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               exec_go  = 1'b1;
               state_in = stfl_pkg::STATE_IDLE;
            end
         end
         default: begin
            state_in = stfl_pkg::STATE_IDLE;
         end
      endcase
   end

   assign accept  = req_valid && !req_stall;
   assign rd_addr = (req_data.op == stfl_pkg::OP_ADD) ? free_head_ff
                                                      : req_data.slot_index[SB-1:0];

   stfl_ram #(
      .WIDTH (EB),
      .DEPTH (stfl_pkg::CAPACITY)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (addr_ff),
      .wr_data (wr_data),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // unwritten entries: free, linked to the next slot, last links to none
   always_comb begin
      if (32'(addr_ff) == stfl_pkg::CAPACITY - 1) begin
         reset_link = '0;
      end else begin
         reset_link = VB'(addr_ff) + VB'(1);
      end
   end

   assign entry   = hit_ff ? rd_data : {1'b0, reset_link};
   assign idx_bad = (req_hold_ff.slot_index == 8'd0)
                 || (32'(req_hold_ff.slot_index) >= stfl_pkg::CAPACITY)
                 || !entry[VB];

   // execute
   always_comb begin
      free_head_in = free_head_ff;
      count_in     = count_ff;
      wr_en        = 1'b0;
      wr_data      = entry;
      rsp_data_in  = '0;
      rsp_data_in.status = stfl_pkg::ST_BAD;
      case (req_hold_ff.op) inside
         stfl_pkg::OP_ADD: begin
            if (free_head_ff == '0) begin
               rsp_data_in.status = stfl_pkg::ST_FULL;
            end else begin
               free_head_in = entry[SB-1:0];
               count_in     = count_ff + SB'(1);
               wr_en        = exec_go;
               wr_data      = {1'b1, VB'(req_hold_ff.item_value)};
               rsp_data_in.status         = stfl_pkg::ST_OK;
               rsp_data_in.assigned_index = 8'(addr_ff);
            end
         end
         stfl_pkg::OP_GET, stfl_pkg::OP_REMOVE: begin
            if (!idx_bad) begin
               rsp_data_in.status     = stfl_pkg::ST_OK;
               rsp_data_in.read_value = 32'(entry[VB-1:0]);
               if (req_hold_ff.op == stfl_pkg::OP_REMOVE) begin
                  free_head_in = addr_ff;
                  if (count_ff != '0) begin
                     count_in = count_ff - SB'(1);
                  end
                  wr_en   = exec_go;
                  wr_data = {1'b0, VB'(free_head_ff)};
               end
            end
         end
         default: begin
            rsp_data_in.status = stfl_pkg::ST_BAD;
         end
      endcase
      rsp_data_in.live_count = 8'(count_in);
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (exec_go) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= stfl_pkg::STATE_IDLE;
         free_head_ff  <= (stfl_pkg::CAPACITY > 1) ? SB'(1) : '0;
         count_ff      <= '0;
         slot_valid_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (exec_go) begin
            free_head_ff <= free_head_in;
            count_ff     <= count_in;
         end
         if (wr_en) begin
            slot_valid_ff[addr_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_hold_ff <= req_data;
         addr_ff     <= rd_addr;
         hit_ff      <= slot_valid_ff[rd_addr];
      end
      if (exec_go) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef NO_ASSERTIONS
   a_head_vs_count: assert property (@(posedge clock) disable iff (reset)
      (free_head_ff == '0) == (32'(count_ff) == stfl_pkg::CAPACITY - 1))
      else $error("free list head disagrees with live count");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == stfl_pkg::ST_FULL
      |-> 32'(rsp_data.live_count) == ((stfl_pkg::CAPACITY - 1) & 32'hFF))
      else $error("full status with slots left");

   a_write_in_exec: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> state_ff == stfl_pkg::STATE_EXEC && exec_go)
      else $error("slot write outside execute");

   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == stfl_pkg::STATE_EXEC)
      else $error("accepted item not executed");
`endif

endmodule

// ===== test/slot_table_with_free_list_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slot_table_with_free_list_tb
// Self-checking bench for the slot table with its embedded free list.
// ----------------------------------------------------------------------------
// Each accepted request runs through a local model of the table, the free
// list and the live count. The model's answer is queued and compared field by
// field with every result, in order. Directed corner cases come first: slot
// zero, free slots, the unused op and extreme values. Random traffic follows,
// with a fill of the whole table, a full drain and random idling on both sides.
// ----------------------------------------------------------------------------
module slot_table_with_free_list_tb;

   localparam logic [1:0] OP_UNUSED  = 2'd3;
   localparam int         IDLE_LIMIT = 4000;
   localparam int         TAIL_WAIT  = 10;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   stfl_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   stfl_pkg::rsp_type rsp_data;

   // table model
   bit          slot_busy [stfl_pkg::CAPACITY];
   logic [31:0] slot_word [stfl_pkg::CAPACITY];
   int          free_top;
   int          occupied_total;

   stfl_pkg::rsp_type pending_answers [$];
   stfl_pkg::rsp_type due_answer;
   int      error_count = 0;
   int      idle_cycles = 0;
   bit      steady = 1'b0;

   slot_table_with_free_list i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   function automatic void clear_table();
      for (int i = 0; i < stfl_pkg::CAPACITY; i++) begin
         slot_busy[i] = 1'b0;
         slot_word[i] = (i + 1 < stfl_pkg::CAPACITY) ? 32'(i + 1) : 32'd0;
      end
      free_top = (stfl_pkg::CAPACITY > 1) ? 1 : 0;
      occupied_total = 0;
   endfunction

   function automatic stfl_pkg::rsp_type apply_slot_op(stfl_pkg::req_type r);
      stfl_pkg::rsp_type a;
      int      h;
      int      s;
      a = '0;
      a.status = stfl_pkg::ST_BAD;
      s = int'(r.slot_index);
      case (r.op)
         stfl_pkg::OP_ADD: begin
            h = free_top;
            if (h == 0 || h >= stfl_pkg::CAPACITY) begin
               a.status = stfl_pkg::ST_FULL;
            end else begin
               free_top = int'(slot_word[h]);
               if (free_top >= stfl_pkg::CAPACITY) free_top = 0;
               slot_word[h] = r.item_value;
               slot_busy[h] = 1'b1;
               occupied_total++;
               a.status = stfl_pkg::ST_OK;
               a.assigned_index = 8'(h);
            end
         end
         stfl_pkg::OP_GET, stfl_pkg::OP_REMOVE: begin
            if (s != 0 && s < stfl_pkg::CAPACITY && slot_busy[s]) begin
               a.status = stfl_pkg::ST_OK;
               a.read_value = slot_word[s];
               if (r.op == stfl_pkg::OP_REMOVE) begin
                  slot_word[s] = 32'(free_top);
                  slot_busy[s] = 1'b0;
                  free_top = s;
                  if (occupied_total > 0) occupied_total--;
               end
            end
         end
         default: ;
      endcase
      a.live_count = 8'(occupied_total);
      return a;
   endfunction

   // pct percent of the time an occupied slot, else any index
   function automatic logic [7:0] pick_slot(int pct);
      int start;
      int s;
      if (occupied_total > 0 && $urandom_range(0, 99) < pct) begin
         start = $urandom_range(1, stfl_pkg::CAPACITY - 1);
         for (int k = 0; k < stfl_pkg::CAPACITY; k++) begin
            s = (start + k) % stfl_pkg::CAPACITY;
            if (slot_busy[s]) return 8'(s);
         end
      end
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic send_op(input logic [1:0] op, input logic [7:0] idx,
                          input logic [31:0] val);
      stfl_pkg::req_type r;
      r.op = op;
      r.slot_index = idx;
      r.item_value = val;
      if (!steady && $urandom_range(0, 99) < 12) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_stall);
      pending_answers.push_back(apply_slot_op(r));
   endtask

   task automatic wait_for_answers();
      req_valid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
   endtask

   task automatic send_random_op(input int add_pct);
      int         roll;
      logic [1:0] op;
      roll = $urandom_range(0, 99);
      if (roll < add_pct) op = stfl_pkg::OP_ADD;
      else if (roll < 96) op = $urandom_range(0, 1) ? stfl_pkg::OP_GET
                                                    : stfl_pkg::OP_REMOVE;
      else op = OP_UNUSED;
      send_op(op, pick_slot(80), $urandom);
   endtask

   task automatic test_edge_cases();
      send_op(stfl_pkg::OP_GET, 8'd0, 32'hffff_ffff);
      send_op(stfl_pkg::OP_REMOVE, 8'd0, 32'd0);
      send_op(stfl_pkg::OP_GET, 8'd1, 32'd0);
      send_op(stfl_pkg::OP_REMOVE, 8'd255, 32'd0);
      send_op(OP_UNUSED, 8'hff, 32'hffff_ffff);
      send_op(stfl_pkg::OP_ADD, 8'd0, 32'd0);
      send_op(stfl_pkg::OP_ADD, 8'hff, 32'hffff_ffff);
      send_op(stfl_pkg::OP_GET, 8'd1, 32'd0);
      send_op(stfl_pkg::OP_GET, 8'd2, 32'd0);
      send_op(stfl_pkg::OP_GET, 8'd255, 32'd0);
      send_op(stfl_pkg::OP_REMOVE, 8'd1, 32'd0);
      send_op(stfl_pkg::OP_ADD, 8'd0, 32'h5a5a_5a5a);
      send_op(stfl_pkg::OP_REMOVE, 8'd2, 32'd0);
      send_op(stfl_pkg::OP_REMOVE, 8'd2, 32'd0);
      send_op(stfl_pkg::OP_GET, 8'd1, 32'd0);
      send_op(OP_UNUSED, 8'd0, 32'd0);
      send_op(stfl_pkg::OP_REMOVE, 8'd1, 32'd0);
      send_op(stfl_pkg::OP_ADD, 8'd0, 32'h1234_5678);
   endtask

   task automatic test_sender_pause();
      repeat (10) send_random_op(50);
      wait_for_answers();
      repeat (10) send_random_op(50);
   endtask

   task automatic test_random_mix(input int count, input int add_pct);
      repeat (count) send_random_op(add_pct);
   endtask

   // no idling during the fill: back-to-back fill to full, then a complete drain with random idling
   task automatic test_fill_and_drain();
      steady = 1'b1;
      while (free_top != 0) begin
         if ($urandom_range(0, 99) < 15) begin
            send_op(stfl_pkg::OP_GET, pick_slot(90), $urandom);
         end else begin
            send_op(stfl_pkg::OP_ADD, pick_slot(0), $urandom);
         end
      end
      repeat (3) send_op(stfl_pkg::OP_ADD, 8'd0, $urandom);
      send_op(stfl_pkg::OP_GET, 8'd255, 32'd0);
      send_op(stfl_pkg::OP_REMOVE, 8'd255, 32'd0);
      send_op(stfl_pkg::OP_ADD, 8'd0, 32'hffff_ffff);
      send_op(stfl_pkg::OP_ADD, 8'd0, 32'd0);
      steady = 1'b0;
      while (occupied_total > 0) begin
         if ($urandom_range(0, 99) < 15) begin
            send_op(stfl_pkg::OP_GET, pick_slot(90), $urandom);
         end else begin
            send_op(stfl_pkg::OP_REMOVE, pick_slot(100), $urandom);
         end
      end
      send_op(stfl_pkg::OP_REMOVE, pick_slot(0), 32'd0);
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %h got %h", $time, name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_answers.size() == 0) begin
               $display("%0t: unexpected result %h", $time, rsp_data);
               error_count++;
            end else begin
               due_answer = pending_answers.pop_front();
               check_field("status", 32'(due_answer.status), 32'(rsp_data.status));
               check_field("assigned_index", 32'(due_answer.assigned_index),
                           32'(rsp_data.assigned_index));
               check_field("read_value", due_answer.read_value, rsp_data.read_value);
               check_field("live_count", 32'(due_answer.live_count),
                           32'(rsp_data.live_count));
            end
         end
         rsp_stall <= !steady && ($urandom_range(0, 99) < 12);
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   initial begin
      clear_table();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_edge_cases();
      test_sender_pause();
      test_random_mix(400, 45);
      test_fill_and_drain();
      test_random_mix(300, 60);
      test_random_mix(150, 35);
      wait_for_answers();
      repeat (TAIL_WAIT) @(posedge clock);
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/stfl_pkg.sv
hw/rtl/stfl_ram.sv
hw/rtl/slot_table_with_free_list.sv
test/slot_table_with_free_list_tb.sv
